// File: hw/rtl/receive_bandwidth_estimator_core_macros.svh
// Assertion macros for the receive bandwidth estimator.
// Included by the modules that carry concurrent checks.
`ifndef RECEIVE_BANDWIDTH_ESTIMATOR_CORE_MACROS_SVH
`define RECEIVE_BANDWIDTH_ESTIMATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RBE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define RBE_ASSERT_NR(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RBE_ASSERT(label, clk, rst_n, prop)
`define RBE_ASSERT_NR(label, clk, prop)
`endif
`endif

// File: hw/rtl/rbe_pkg.sv
// Shared types and constants for the receive bandwidth estimator.
// No dependencies.
`timescale 1ns / 1ps
package rbe_pkg;
	localparam logic [1:0] CFG_MIN_DGRAMS = 2'd0;
	localparam logic [1:0] CFG_MIN_USEC   = 2'd1;
	localparam logic [1:0] CFG_MAX_USEC   = 2'd2;
	localparam logic [19:0] USEC_PER_SEC  = 20'd1000000;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} rbe_div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} rbe_div_rsp_t;
endpackage

// File: hw/rtl/rbe_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on rbe_pkg.
`timescale 1ns / 1ps
`include "receive_bandwidth_estimator_core_macros.svh"
module rbe_divider (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rbe_pkg::rbe_div_req_t req,
	output rbe_pkg::rbe_div_rsp_t rsp
);
	import rbe_pkg::*;

	logic [63:0] rem_q, quo_q, den_q;
	logic [6:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] shifted;
	logic [64:0] trial;

	assign shifted = {rem_q, quo_q[63]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	`RBE_ASSERT(a_done_after_busy, clk, arst_n, done_q |-> $past(busy_q))
	`RBE_ASSERT(a_no_start_busy, clk, arst_n, busy_q |-> !done_q)
	`RBE_ASSERT(a_cnt_idle, clk, arst_n, !busy_q && !$past(req.start) |-> cnt_q == 7'd0 || cnt_q == 7'd64)
endmodule

// File: hw/rtl/receive_bandwidth_estimator_core.sv
// Receive bandwidth estimator top level: datagram tracking and interval close.
// Depends on rbe_pkg and rbe_divider.
//
//   channel | direction | handshake         | payload
//   in      | to block  | in_valid/in_stall | datagram fields
//   out     | from block| out_valid/out_stall| measurement fields
//   cfg     | to block  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A request that closes no interval goes to S_OUT, which raises out_valid. A
// closing request runs the shared 64-step divider for the rate (skipped when
// the interval length is zero) and again for the loss fraction (skipped unless
// loss is positive), passing S_RATE_MUL, S_RATE_DIV and S_LOSS_DIV, then
// S_FINISH and S_OUT. The output register holds one result; in_stall stays high
// from acceptance until that result is taken. Reset clears all tracking state
// and restores register defaults.
`timescale 1ns / 1ps
`include "receive_bandwidth_estimator_core_macros.svh"
module receive_bandwidth_estimator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] sequence_number,
	input  logic [63:0] receive_time_usec,
	input  logic [23:0] delay_stamp,
	input  logic [31:0] trip_time_usec,
	input  logic [15:0] datagram_bytes,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        measurement_updated,
	output logic [63:0] measurement_time_usec,
	output logic [31:0] probe_bytes_per_sec,
	output logic [31:0] goodput_bytes_per_sec,
	output logic [15:0] loss_fraction,
	output logic [31:0] smoothed_min_trip_usec,
	output logic [31:0] max_trip_usec,
	output logic [23:0] min_delay_stamp,
	output logic [31:0] smoothed_gap_usec,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import rbe_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_RATE_MUL, S_RATE_DIV, S_LOSS_DIV, S_FINISH, S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] min_dgrams_q;
	logic [31:0] min_usec_q, max_usec_q;

	// tracking state
	logic [31:0] start_seq_q, prev_seq_q, expected_seq_q, prev_trip_q;
	logic [63:0] start_time_q, prev_time_q, gap_last_time_q, meas_time_q;
	logic [23:0] prev_stamp_q, meas_min_stamp_q;
	logic        seeking_q;
	logic [31:0] ivl_max_trip_q, ivl_bytes_q, ivl_count_q, gap_max_q, gap_smoothed_q;
	logic [31:0] meas_probe_q, meas_goodput_q, meas_min_trip_q, meas_max_trip_q;
	logic [15:0] meas_loss_q;

	// close bookkeeping: the closing request is held here while the divider runs
	logic [31:0] iv_q, new_seq_q, new_trip_q, cls_count_q;
	logic [63:0] new_time_q;
	logic [23:0] new_stamp_q;
	logic [15:0] new_bytes_q;
	logic [15:0] plr_q;
	logic [63:0] prod_q;
	logic        updated_q, out_valid_q;

	rbe_div_req_t div_req;
	rbe_div_rsp_t div_rsp;

	rbe_divider u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	logic in_acc;
	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE) || out_valid_q;
	assign cfg_ready = 1'b1;

	// datagram evaluation (combinational front end)
	logic [63:0] dt;
	logic        dt_ok;
	logic [32:0] seq_rel;
	logic        reordered;
	logic [23:0] ds;
	logic [31:0] iv;
	logic [31:0] exp_d;
	logic        normal, timeout, do_close;
	logic [32:0] bytes_sum;
	logic [31:0] bytes_sat;

	always_comb begin
		dt        = receive_time_usec - gap_last_time_q;
		dt_ok     = (dt != 64'd0) && !dt[63];
		seq_rel   = {1'b0, sequence_number - expected_seq_q};
		reordered = seq_rel[31];
		ds        = delay_stamp - prev_stamp_q;
		iv        = prev_time_q[31:0] - start_time_q[31:0];
		exp_d     = prev_seq_q - start_seq_q;
		normal    = (ivl_count_q >= {16'd0, min_dgrams_q}) && (iv >= min_usec_q) &&
		            ({1'b0, iv} >= {gap_smoothed_q, 1'b0});
		timeout   = (iv >= max_usec_q) && !exp_d[31] && (exp_d > 32'd2);
		do_close  = seeking_q && ds != 24'd0 && !ds[23] && (normal || timeout);
		bytes_sum = {1'b0, ivl_bytes_q} + {17'd0, datagram_bytes};
		bytes_sat = bytes_sum[32] ? 32'hFFFFFFFF : bytes_sum[31:0];
	end

	// loss numbers from snapshot
	logic [31:0] exp_s;
	logic [32:0] lost_s;
	logic        loss_ok;
	always_comb begin
		exp_s   = prev_seq_q - start_seq_q;
		lost_s  = {exp_s[31], exp_s} - {1'b0, cls_count_q};
		loss_ok = !exp_s[31] && exp_s != 32'd0 && !lost_s[32] && lost_s != 33'd0;
	end

	function automatic logic [31:0] avg78(input logic [31:0] old, input logic [31:0] v);
		logic [35:0] s;
		s = {1'b0, old, 3'b000} - {4'd0, old} + {4'd0, v};
		return s[34:3];
	endfunction

	always_comb begin
		div_req = '0;
		if (state_q == S_RATE_MUL) begin
			div_req.start    = (iv_q != 32'd0);
			div_req.dividend = prod_q;
			div_req.divisor  = {32'd0, iv_q};
		end else if (state_q == S_RATE_DIV && (div_rsp.done || iv_q == 32'd0)) begin
			div_req.start    = loss_ok;
			div_req.dividend = {15'd0, lost_s, 16'd0};
			div_req.divisor  = {32'd0, exp_s};
		end
	end

	// hold state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			min_dgrams_q <= 16'd10;
			min_usec_q <= 32'd10000;
			max_usec_q <= 32'd200000;
			start_seq_q <= '0; prev_seq_q <= '0; expected_seq_q <= '0; prev_trip_q <= '0;
			start_time_q <= '0; prev_time_q <= '0; gap_last_time_q <= '0; meas_time_q <= '0;
			prev_stamp_q <= '0; meas_min_stamp_q <= '0; seeking_q <= 1'b0;
			ivl_max_trip_q <= '0; ivl_bytes_q <= '0; ivl_count_q <= '0;
			gap_max_q <= '0; gap_smoothed_q <= '0;
			meas_probe_q <= '0; meas_goodput_q <= '0; meas_min_trip_q <= '0;
			meas_max_trip_q <= '0; meas_loss_q <= '0;
			updated_q <= 1'b0; out_valid_q <= 1'b0;
			iv_q <= '0; new_seq_q <= '0; new_trip_q <= '0; cls_count_q <= '0;
			new_time_q <= '0; new_stamp_q <= '0; new_bytes_q <= '0;
			plr_q <= '0; prod_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_MIN_DGRAMS: min_dgrams_q <= cfg_data[15:0];
					CFG_MIN_USEC:   min_usec_q   <= cfg_data;
					CFG_MAX_USEC:   max_usec_q   <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						updated_q <= 1'b0;
						if (start_seq_q == 32'd0) begin
							start_seq_q <= sequence_number; start_time_q <= receive_time_usec;
							prev_seq_q <= sequence_number; prev_time_q <= receive_time_usec;
							prev_stamp_q <= delay_stamp; prev_trip_q <= trip_time_usec;
							state_q <= S_OUT;
						end else begin
							if (dt_ok) begin
								if (dt < {32'd0, max_usec_q} && gap_last_time_q != 64'd0 &&
								    {32'd0, gap_max_q} < dt)
									gap_max_q <= dt[31:0];
								gap_last_time_q <= receive_time_usec;
							end
							if (reordered) begin
								ivl_bytes_q <= bytes_sat;
								state_q <= S_OUT;
							end else begin
								expected_seq_q <= sequence_number + 32'd1;
								if (seeking_q) begin
									if (ds != 24'd0 && !ds[23]) begin
										seeking_q <= 1'b0;
										ivl_max_trip_q <= trip_time_usec;
									end
								end else if (ds[23]) begin
									seeking_q <= 1'b1;
								end else if (ivl_max_trip_q < trip_time_usec) begin
									ivl_max_trip_q <= trip_time_usec;
								end
								if (do_close) begin
									// snapshot close inputs and the request; prev_* still old
									iv_q        <= iv;
									new_seq_q   <= sequence_number;
									new_time_q  <= receive_time_usec;
									new_stamp_q <= delay_stamp;
									new_trip_q  <= trip_time_usec;
									new_bytes_q <= datagram_bytes;
									cls_count_q <= ivl_count_q;
									prod_q <= {32'd0, ivl_bytes_q} * {44'd0, USEC_PER_SEC};
									meas_max_trip_q <= (meas_max_trip_q == 32'd0) ?
										ivl_max_trip_q : avg78(meas_max_trip_q, ivl_max_trip_q);
									state_q <= S_RATE_MUL;
								end else begin
									prev_seq_q <= sequence_number; prev_time_q <= receive_time_usec;
									prev_stamp_q <= delay_stamp; prev_trip_q <= trip_time_usec;
									ivl_bytes_q <= bytes_sat;
									if (ivl_count_q != 32'hFFFFFFFF) ivl_count_q <= ivl_count_q + 32'd1;
									state_q <= S_OUT;
								end
							end
						end
					end
				end
				S_RATE_MUL: begin
					if (iv_q == 32'd0) meas_probe_q <= '0;
					state_q <= S_RATE_DIV;
				end
				S_RATE_DIV: begin
					if (div_rsp.done || iv_q == 32'd0) begin
						if (iv_q != 32'd0)
							meas_probe_q <= (div_rsp.quotient[63:32] != 32'd0) ?
								32'hFFFFFFFF : div_rsp.quotient[31:0];
						plr_q <= '0;
						state_q <= loss_ok ? S_LOSS_DIV : S_FINISH;
					end
				end
				S_LOSS_DIV: begin
					if (div_rsp.done) begin
						plr_q <= (div_rsp.quotient[63:16] != 48'd0) ?
							16'hFFFF : div_rsp.quotient[15:0];
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					// fold close results, then take the held request as the new prev
					meas_time_q <= prev_time_q;
					meas_loss_q <= 16'((({3'd0, meas_loss_q} << 3) - {3'd0, meas_loss_q} +
						{3'd0, plr_q}) >> 3);
					meas_goodput_q <= (meas_goodput_q == 32'd0) ? meas_probe_q :
						avg78(meas_goodput_q, meas_probe_q);
					meas_min_trip_q <= (meas_min_trip_q == 32'd0) ? prev_trip_q :
						avg78(meas_min_trip_q, prev_trip_q);
					meas_min_stamp_q <= prev_stamp_q;
					if (gap_max_q != 32'd0) begin
						gap_smoothed_q <= avg78(gap_smoothed_q, gap_max_q);
						gap_max_q <= '0;
					end
					start_seq_q  <= prev_seq_q;
					start_time_q <= prev_time_q;
					prev_seq_q   <= new_seq_q; prev_time_q <= new_time_q;
					prev_stamp_q <= new_stamp_q; prev_trip_q <= new_trip_q;
					ivl_bytes_q  <= {16'd0, new_bytes_q};
					ivl_count_q  <= 32'd1;
					updated_q    <= 1'b1;
					state_q      <= S_OUT;
				end
				S_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid              = out_valid_q;
	assign measurement_updated    = updated_q;
	assign measurement_time_usec  = meas_time_q;
	assign probe_bytes_per_sec    = meas_probe_q;
	assign goodput_bytes_per_sec  = meas_goodput_q;
	assign loss_fraction          = meas_loss_q;
	assign smoothed_min_trip_usec = meas_min_trip_q;
	assign max_trip_usec          = meas_max_trip_q;
	assign min_delay_stamp        = meas_min_stamp_q;
	assign smoothed_gap_usec      = gap_smoothed_q;

	`RBE_ASSERT(a_busy_stalls, clk, arst_n, state_q != S_IDLE |-> in_stall)
	`RBE_ASSERT(a_out_after_seq, clk, arst_n, $rose(out_valid_q) |-> $past(state_q) == S_OUT)
	`RBE_ASSERT(a_upd_close, clk, arst_n, $rose(updated_q) |-> $past(state_q) == S_FINISH)
	`RBE_ASSERT(a_count_nonzero_after_close, clk, arst_n, $past(state_q) == S_FINISH && !$past(out_valid_q) |-> ivl_count_q == 32'd1)
endmodule
